/* src/otl_pkg.sv */
// Shared types, field widths and codes for the overwriting trace log.
package otl_pkg;

	// Field widths
	localparam int CAP_W = 11;
	localparam int OFF_W = 10;
	localparam int SEQ_W = 64;
	localparam int PL_W  = 64;
	localparam int TS_W  = 64;
	localparam int WID_W = 8;

	// Defaults
	localparam int DEPTH_DEFAULT = 1024;
	localparam int CAP_RESET     = 1024;
	localparam int CAP_LIMIT     = 2047;

	// Request and status codes
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_READ   = 1'b1;
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_RANGE   = 1'b1;

	// Input transaction
	typedef struct packed {
		logic             req_type;
		logic [PL_W-1:0]  entry_payload;
		logic [WID_W-1:0] writer_id;
		logic [TS_W-1:0]  time_stamp;
		logic [OFF_W-1:0] read_offset;
	} otl_req_t;

	// Result transaction
	typedef struct packed {
		logic             status;
		logic [SEQ_W-1:0] out_seq;
		logic [WID_W-1:0] out_writer;
		logic [TS_W-1:0]  out_time;
		logic [PL_W-1:0]  out_payload;
		logic [CAP_W-1:0] entry_count;
	} otl_rsp_t;

	// One stored log entry
	typedef struct packed {
		logic [SEQ_W-1:0] seq;
		logic [WID_W-1:0] writer;
		logic [TS_W-1:0]  stamp;
		logic [PL_W-1:0]  payload;
	} otl_entry_t;

	// Memory port strobes
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} otl_mem_ctl_t;

	// Request summary held while the memory read completes
	typedef struct packed {
		logic             read_hit;
		logic             status;
		logic [SEQ_W-1:0] seq;
		logic [CAP_W-1:0] count;
	} otl_info_t;

endpackage

/* src/otl_store.sv */
// Entry memory of the trace log: one write port, one registered read port.
module otl_store #(
	parameter int DEPTH = otl_pkg::DEPTH_DEFAULT
) (
	input  logic                   clk,
	input  otl_pkg::otl_mem_ctl_t  mem_ctl,
	input  logic [$clog2(DEPTH)-1:0] mem_addr,
	input  otl_pkg::otl_entry_t    mem_wdata,
	output otl_pkg::otl_entry_t    mem_rdata
);

	otl_pkg::otl_entry_t mem_q [DEPTH];

	// Write on append
	always_ff @(posedge clk) begin
		if (mem_ctl.wr_en) begin
			mem_q[mem_addr] <= mem_wdata;
		end
	end

	// Registered read, held until the next read
	always_ff @(posedge clk) begin
		if (mem_ctl.rd_en) begin
			mem_rdata <= mem_q[mem_addr];
		end
	end

endmodule

/* src/otl_ctrl.sv */
// Pointer, count and sequence state; memory address and strobe generation.
module otl_ctrl #(
	parameter int DEPTH = otl_pkg::DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_fire,
	input  logic [otl_pkg::CAP_W-1:0]    cfg_data,
	input  logic                         in_fire,
	input  otl_pkg::otl_req_t            req,
	output otl_pkg::otl_mem_ctl_t        mem_ctl,
	output logic [$clog2(DEPTH)-1:0]     mem_addr,
	output otl_pkg::otl_entry_t          mem_wdata,
	output otl_pkg::otl_info_t           info_s1
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int AW = ((PTR_W > otl_pkg::CAP_W) ? PTR_W : otl_pkg::CAP_W) + 1;
	localparam int CAP_MAX = (DEPTH < otl_pkg::CAP_LIMIT) ? DEPTH : otl_pkg::CAP_LIMIT;
	localparam int CAP_RST = (otl_pkg::CAP_RESET < DEPTH) ? otl_pkg::CAP_RESET : DEPTH;
	localparam logic [otl_pkg::CAP_W-1:0] CAP_MAX_V = otl_pkg::CAP_W'(CAP_MAX);
	localparam logic [otl_pkg::CAP_W-1:0] CAP_RST_V = otl_pkg::CAP_W'(CAP_RST);

	logic [PTR_W-1:0]          head_q;
	logic [PTR_W-1:0]          oldest_q;
	logic [otl_pkg::CAP_W-1:0] count_q;
	logic [otl_pkg::CAP_W-1:0] cap_q;
	logic [otl_pkg::SEQ_W-1:0] seq_q;

	logic [otl_pkg::CAP_W-1:0] cap_new;
	logic [PTR_W-1:0]          head_inc;
	logic [PTR_W-1:0]          oldest_inc;
	logic [AW-1:0]             head_ext;
	logic [AW-1:0]             oldest_ext;
	logic [AW-1:0]             idx_sum;
	logic [AW-1:0]             idx_wrap;
	logic                      is_read;
	logic                      read_hit;
	logic                      not_full;

	// Capacity clamp: zero means one, above the smaller of the memory depth and 2047 means that bound
	always_comb begin
		if (cfg_data == '0) begin
			cap_new = otl_pkg::CAP_W'(1);
		end else if (cfg_data > CAP_MAX_V) begin
			cap_new = CAP_MAX_V;
		end else begin
			cap_new = cfg_data;
		end
	end

	// Pointer increments wrapping at the capacity
	always_comb begin
		head_ext   = AW'(head_q) + AW'(1);
		oldest_ext = AW'(oldest_q) + AW'(1);
		head_inc   = (head_ext >= AW'(cap_q)) ? '0 : head_ext[PTR_W-1:0];
		oldest_inc = (oldest_ext >= AW'(cap_q)) ? '0 : oldest_ext[PTR_W-1:0];
	end

	// Read index: oldest plus offset, modulo capacity
	always_comb begin
		is_read  = (req.req_type == otl_pkg::REQ_READ);
		read_hit = (otl_pkg::CAP_W'(req.read_offset) < count_q);
		idx_sum  = AW'(oldest_q) + AW'(req.read_offset);
		idx_wrap = (idx_sum >= AW'(cap_q)) ? (idx_sum - AW'(cap_q)) : idx_sum;
		not_full = (count_q < cap_q);
	end

	// Memory port
	always_comb begin
		mem_ctl.wr_en     = in_fire && !is_read;
		mem_ctl.rd_en     = in_fire && is_read && read_hit;
		mem_addr          = is_read ? idx_wrap[PTR_W-1:0] : head_q;
		mem_wdata.seq     = seq_q;
		mem_wdata.writer  = req.writer_id;
		mem_wdata.stamp   = req.time_stamp;
		mem_wdata.payload = req.entry_payload;
	end

	// Log state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			oldest_q <= '0;
			count_q  <= '0;
			cap_q    <= CAP_RST_V;
			seq_q    <= '0;
		end else if (cfg_fire) begin
			head_q   <= '0;
			oldest_q <= '0;
			count_q  <= '0;
			cap_q    <= cap_new;
		end else if (in_fire && !is_read) begin
			head_q <= head_inc;
			seq_q  <= seq_q + otl_pkg::SEQ_W'(1);
			if (not_full) begin
				count_q <= count_q + otl_pkg::CAP_W'(1);
			end else begin
				oldest_q <= oldest_inc;
			end
		end
	end

	// Request summary, lined up with the memory read data
	always_ff @(posedge clk) begin
		if (in_fire) begin
			info_s1.read_hit <= is_read && read_hit;
			info_s1.status   <= (is_read && !read_hit) ? otl_pkg::ST_RANGE : otl_pkg::ST_OK;
			info_s1.seq      <= is_read ? '0 : seq_q;
			if (!is_read && not_full) begin
				info_s1.count <= count_q + otl_pkg::CAP_W'(1);
			end else begin
				info_s1.count <= count_q;
			end
		end
	end

endmodule

/* src/overwriting_trace_log_core.sv */
// Top level of the overwriting trace log: handshakes, read stage and result register.
//
// Usage
//   in channel  (in_valid/in_ready/in_data): one request per transaction, either an
//     append of payload, writer id and timestamp, or a read at an offset from the
//     oldest entry.
//   out channel (out_valid/out_ready/out_data): exactly one result per request, in
//     request order, carrying status, sequence number, entry fields and entry count.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the log capacity and empties
//     the log; the sequence counter is kept. Write only while no request is in flight.
// Timing
//   An accepted request passes the synchronous entry memory read, then the result
//   register. A new request is accepted every cycle unless out_ready stalls the
//   result; the memory's single port sets that figure.
// Reset
//   arst_n clears pointers, count and sequence counter and sets the capacity to 1024
//   (or DEPTH if smaller). Entry memory contents are not cleared and need no pass.
// Stall
//   If out_ready stays low, the result register and the read stage fill and in_ready
//   drops; nothing is lost or repeated.
module overwriting_trace_log_core #(
	parameter int DEPTH = otl_pkg::DEPTH_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [otl_pkg::CAP_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  otl_pkg::otl_req_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output otl_pkg::otl_rsp_t         out_data
);

	otl_pkg::otl_mem_ctl_t   mem_ctl;
	logic [$clog2(DEPTH)-1:0] mem_addr;
	otl_pkg::otl_entry_t     mem_wdata;
	otl_pkg::otl_entry_t     mem_rdata;
	otl_pkg::otl_info_t      info_s1;

	logic valid_s1;
	logic out_valid_q;
	logic in_fire;
	logic cfg_fire;
	logic advance;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	otl_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_fire (cfg_fire),
		.cfg_data (cfg_data),
		.in_fire  (in_fire),
		.req      (in_data),
		.mem_ctl  (mem_ctl),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.info_s1  (info_s1)
	);

	otl_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk      (clk),
		.mem_ctl  (mem_ctl),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	// Read stage occupancy and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register: memory entry fields only for a read that hit, else the held sequence number and zeros
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data.status      <= info_s1.status;
			out_data.entry_count <= info_s1.count;
			if (info_s1.read_hit) begin
				out_data.out_seq     <= mem_rdata.seq;
				out_data.out_writer  <= mem_rdata.writer;
				out_data.out_time    <= mem_rdata.stamp;
				out_data.out_payload <= mem_rdata.payload;
			end else begin
				out_data.out_seq     <= info_s1.seq;
				out_data.out_writer  <= '0;
				out_data.out_time    <= '0;
				out_data.out_payload <= '0;
			end
		end
	end

endmodule
